@@ design/bdq_pkg.sv @@
package bdq_pkg;

  // Default sizing of the element store.
  localparam int unsigned CAPACITY_DEF      = 16;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  // Fixed widths of the command and result fields.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned LEN_W   = 5;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  // One command beat.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] popped_value;
    logic               found;
    logic [LEN_W-1:0]   length;
  } result_t;

endpackage

@@ design/bdq_mem.sv @@
module bdq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bounded_deque_with_search.sv @@
// Push, clear, refused pops, searches of an empty deque and unknown commands: the result
// appears in the cycle after the beat is accepted, and a new command can be taken in
// every cycle. Pop: one memory read, registered, with the block busy in ST_POP; then
// the result is registered. Search: busy in ST_SEARCH while elements are read in turn
// from the front, to a match or the last (at most length); the single read port sets this.
// Reset clears the pointers, the length and the control state; the store is not cleared.
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY      = CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    done_o,
  output result_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = $clog2(2 * CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_POP    = 3'b010,
    ST_SEARCH = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          fp_q, fp_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic [ELEMENT_WIDTH-1:0] key_q, key_d;
  logic                   done_q, done_d;
  result_t                res_q, res_d;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;

  logic [ELEMENT_WIDTH-1:0] v_elem;
  logic [AW-1:0]          fp_dec, fp_inc, back_slot, last_slot, next_addr;
  logic                   full, empty, hit, last;

  // Fold a sum below twice the capacity back into the index range.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] a);
    logic [SW-1:0] cap;
    cap = SW'(CAPACITY);
    return (a >= cap) ? AW'(a - cap) : AW'(a);
  endfunction

  assign v_elem    = ELEMENT_WIDTH'(cmd_i.value);
  assign fp_dec    = (fp_q == '0) ? AW'(CAPACITY - 1) : fp_q - AW'(1);
  assign fp_inc    = wrap(SW'(fp_q) + SW'(1));
  assign back_slot = wrap(SW'(fp_q) + SW'(cnt_q));
  assign last_slot = wrap(SW'(fp_q) + SW'(cnt_q) - SW'(1));
  assign next_addr = wrap(SW'(addr_q) + SW'(1));
  assign full      = (cnt_q == CW'(CAPACITY));
  assign empty     = (cnt_q == '0);
  assign hit       = (mem_rdata == key_q);
  assign last      = (idx_q == cnt_q - CW'(1));

  // Command sequencer: pointer updates happen at acceptance, reads complete later.
  always_comb begin
    state_d   = state_q;
    fp_d      = fp_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    key_d     = key_q;
    done_d    = 1'b0;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = back_slot;
    mem_wdata = v_elem;
    mem_re    = 1'b0;
    mem_raddr = fp_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.command)
            CMD_PUSH_FRONT: begin
              done_d = 1'b1;
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = fp_dec;
                fp_d      = fp_dec;
                cnt_d     = cnt_q + CW'(1);
                res_d.ok  = 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              done_d = 1'b1;
              if (!full) begin
                mem_we   = 1'b1;
                cnt_d    = cnt_q + CW'(1);
                res_d.ok = 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                mem_re  = 1'b1;
                fp_d    = fp_inc;
                cnt_d   = cnt_q - CW'(1);
                state_d = ST_POP;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                done_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = last_slot;
                cnt_d     = cnt_q - CW'(1);
                state_d   = ST_POP;
              end
            end
            CMD_SEARCH: begin
              key_d = v_elem;
              if (empty) begin
                done_d   = 1'b1;
                res_d.ok = 1'b1;
              end else begin
                mem_re  = 1'b1;
                addr_d  = fp_q;
                idx_d   = '0;
                state_d = ST_SEARCH;
              end
            end
            CMD_CLEAR: begin
              done_d   = 1'b1;
              fp_d     = '0;
              cnt_d    = '0;
              res_d.ok = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_POP: begin
        done_d             = 1'b1;
        res_d.ok           = 1'b1;
        res_d.popped_value = VALUE_W'(mem_rdata);
        state_d            = ST_IDLE;
      end

      ST_SEARCH: begin
        // Compare the element read last cycle while fetching the next one.
        if (hit || last) begin
          done_d      = 1'b1;
          res_d.ok    = 1'b1;
          res_d.found = hit;
          state_d     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_addr;
          addr_d    = next_addr;
          idx_d     = idx_q + CW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.length = LEN_W'(cnt_d);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fp_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fp_q    <= fp_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Search bookkeeping and the result register.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    addr_q <= addr_d;
    key_q  <= key_d;
    if (done_d) begin
      res_q <= res_d;
    end
  end

  // Element store; writes happen only while idle, so reads never overlap them.
  bdq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ design/bdq_checker.sv @@
module bdq_checker
  import bdq_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd_i,
  input logic    done_o,
  input result_t res_o
);

  // A result beat never appears while a command is still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");

  // A found element implies a successful command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> res_o.ok)
    else $error("found without ok");

  // A nonzero popped element only comes with a successful pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.popped_value != '0)) |-> (res_o.ok && !res_o.found))
    else $error("popped element on a failed command");

  // Pushes, clears and unknown codes answer in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !(cmd_i.command == CMD_POP_FRONT || cmd_i.command == CMD_POP_BACK
      || cmd_i.command == CMD_SEARCH))
    |=> done_o)
    else $error("single cycle command without result");

  // A clear always succeeds and empties the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CMD_CLEAR) |=> (res_o.ok && res_o.length == '0))
    else $error("clear did not empty the queue");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);
